// ===== sv/disparity_hole_fill_row_unit_defines.svh =====
// assertion macros shared by the hole fill row unit
`ifndef DISPARITY_HOLE_FILL_ROW_UNIT_DEFINES_SVH
`define DISPARITY_HOLE_FILL_ROW_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DHF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DHF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dhf_pkg.sv =====
// types and constants of the disparity hole fill row unit
`default_nettype none
package dhf_pkg;

    localparam int PIX_W    = 16;
    localparam int CNT_W    = 11;
    localparam int FILL_W   = 10;
    localparam int TOT_W    = 21;
    localparam int CFG_W    = 11;
    localparam int SKIP_W   = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [PIX_W-1:0] INVALID_CODE = 16'hFFF0;
    localparam logic [TOT_W-1:0] TOTAL_MAX    = 21'h1FFFFF;

    localparam logic [CFG_W-1:0]  ROW_WIDTH_RST = 11'd640;
    localparam logic [CFG_W-1:0]  ROW_COUNT_RST = 11'd480;
    localparam logic [SKIP_W-1:0] SKIP_RST      = 10'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WIDTH = 2'd0,
        CFG_ROW_COUNT = 2'd1,
        CFG_SKIP_COLS = 2'd2
    } t_cfg_idx;

endpackage
`default_nettype wire

// ===== sv/dhf_pix_if.sv =====
// input channel carrying one disparity pixel per item
`default_nettype none
interface dhf_pix_if;
    import dhf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PIX_W-1:0]  disparity;

    modport source (output valid, output disparity, input ready);
    modport sink   (input valid, input disparity, output ready);
endinterface
`default_nettype wire

// ===== sv/dhf_res_if.sv =====
// output channel carrying one run-length coded result per item
`default_nettype none
interface dhf_res_if;
    import dhf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PIX_W-1:0]  fill_value;
    logic [CNT_W-1:0]         repeat_count;
    logic [FILL_W-1:0]        filled_here;
    logic [TOT_W-1:0]         filled_total;
    logic                     end_of_row;
    logic                     end_of_map;

    modport source (output valid, output fill_value, output repeat_count,
                    output filled_here, output filled_total, output end_of_row,
                    output end_of_map, input ready);
    modport sink   (input valid, input fill_value, input repeat_count,
                    input filled_here, input filled_total, input end_of_row,
                    input end_of_map, output ready);
endinterface
`default_nettype wire

// ===== sv/disparity_hole_fill_row_unit.sv =====
// disparity hole fill per row with run-length coded results
//
//   channel   dir  payload                                        handshake
//   i_pix     in   disparity                                      valid/ready
//   o_res     out  fill_value repeat_count filled_here            valid/ready
//                  filled_total end_of_row end_of_map
//   i_cfg     in   i_cfg_idx i_cfg_data                           i_cfg_we
//
// one pixel per cycle unless o_res stalls: the decision and counter
// updates sit between the input handshake and a single result register
// pixels inside a fill run give no result; the closing pixel gives one
// input is taken whenever the result register is empty or being drained
// synchronous active-low reset clears position, run and total state and
// loads the geometry registers with 640 x 480, no skipped columns
`default_nettype none
`include "disparity_hole_fill_row_unit_defines.svh"
module disparity_hole_fill_row_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    dhf_pix_if.sink                              i_pix,
    dhf_res_if.source                            o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [dhf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [dhf_pkg::CFG_W-1:0]       i_cfg_data
);
    import dhf_pkg::*;

    localparam int CIW  = $clog2(MAX_WIDTH);
    localparam int RIW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RLW  = $clog2(MAX_WIDTH + 1);
    localparam int WDW0 = $clog2(MAX_WIDTH + 1);
    localparam int HDW0 = $clog2(MAX_HEIGHT + 1);
    localparam int WDW  = (WDW0 > CFG_W) ? WDW0 : CFG_W;
    localparam int HDW  = (HDW0 > CFG_W) ? HDW0 : CFG_W;
    localparam int SCW  = (CIW > SKIP_W) ? CIW : SKIP_W;

    // geometry registers
    logic [CFG_W-1:0]  r_row_width;
    logic [CFG_W-1:0]  r_row_count;
    logic [SKIP_W-1:0] r_skip;

    // row and run state
    logic [CIW-1:0]    r_col, n_col;
    logic [RIW-1:0]    r_row, n_row;
    logic              r_past_lead, n_past_lead;
    logic              r_inside_run, n_inside_run;
    logic [RLW-1:0]    r_run_len, n_run_len;
    logic [TOT_W-1:0]  r_total, n_total;

    // result register
    logic                     r_out_valid;
    logic signed [PIX_W-1:0]  r_fill_value;
    logic [CNT_W-1:0]         r_repeat_count;
    logic [FILL_W-1:0]        r_filled_here;
    logic [TOT_W-1:0]         r_filled_total;
    logic                     r_end_of_row;
    logic                     r_end_of_map;

    logic              w_in_ready;
    logic              w_take;
    logic              w_emit;
    logic              w_marker;
    logic              w_negative;
    logic [WDW-1:0]    w_width;
    logic [HDW-1:0]    w_height;
    logic              w_end_row;
    logic              w_end_map;
    logic [RLW-1:0]    w_run_used;
    logic [RLW-1:0]    w_count;
    logic [TOT_W:0]    w_total_sum;
    logic [TOT_W-1:0]  w_total_sat;

    assign w_in_ready = !r_out_valid || o_res.ready;
    assign w_take     = i_pix.valid && w_in_ready;
    assign w_marker   = (i_pix.disparity == INVALID_CODE);
    assign w_negative = i_pix.disparity[PIX_W-1];

    // clamp geometry into 1..MAX
    always_comb begin
        w_width = WDW'(r_row_width);
        if (w_width == '0) begin
            w_width = WDW'(1);
        end else if (w_width > WDW'(MAX_WIDTH)) begin
            w_width = WDW'(MAX_WIDTH);
        end
        w_height = HDW'(r_row_count);
        if (w_height == '0) begin
            w_height = HDW'(1);
        end else if (w_height > HDW'(MAX_HEIGHT)) begin
            w_height = HDW'(MAX_HEIGHT);
        end
    end

    assign w_end_row   = (WDW'(r_col) + WDW'(1)) >= w_width;
    assign w_end_map   = w_end_row && ((HDW'(r_row) + HDW'(1)) >= w_height);
    assign w_run_used  = r_inside_run ? r_run_len : '0;
    assign w_count     = w_run_used + RLW'(1);
    assign w_total_sum = (TOT_W+1)'(r_total) + (TOT_W+1)'(w_run_used);
    assign w_total_sat = w_total_sum[TOT_W] ? TOTAL_MAX : w_total_sum[TOT_W-1:0];

    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_past_lead  = r_past_lead;
        n_inside_run = r_inside_run;
        n_run_len    = r_run_len;
        n_total      = r_total;
        w_emit       = 1'b0;
        if (w_take) begin
            if (r_inside_run) begin
                if (w_negative && !w_end_row) begin
                    n_run_len = r_run_len + RLW'(1);
                    n_col     = r_col + CIW'(1);
                end else begin
                    w_emit       = 1'b1;
                    n_inside_run = 1'b0;
                    n_run_len    = '0;
                end
            end else if (SCW'(r_col) < SCW'(r_skip)) begin
                w_emit = 1'b1;
            end else if (!r_past_lead) begin
                if (!w_marker) begin
                    n_past_lead = 1'b1;
                end
                w_emit = 1'b1;
            end else if (w_marker && !w_end_row) begin
                // marker opens a run
                n_inside_run = 1'b1;
                n_run_len    = RLW'(1);
                n_col        = r_col + CIW'(1);
            end else begin
                w_emit = 1'b1;
            end

            if (w_emit) begin
                n_total = w_total_sat;
                if (w_end_row) begin
                    n_col        = '0;
                    n_past_lead  = 1'b0;
                    n_inside_run = 1'b0;
                    n_run_len    = '0;
                    if (w_end_map) begin
                        n_row   = '0;
                        n_total = '0;
                    end else begin
                        n_row = r_row + RIW'(1);
                    end
                end else begin
                    n_col = r_col + CIW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RST;
            r_row_count <= ROW_COUNT_RST;
            r_skip      <= SKIP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_WIDTH: r_row_width <= i_cfg_data;
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_SKIP_COLS: r_skip      <= i_cfg_data[SKIP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_past_lead  <= 1'b0;
            r_inside_run <= 1'b0;
            r_run_len    <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_past_lead  <= n_past_lead;
            r_inside_run <= n_inside_run;
            r_run_len    <= n_run_len;
            r_total      <= n_total;
            if (w_in_ready) begin
                r_out_valid <= w_take && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_fill_value   <= i_pix.disparity;
            r_repeat_count <= CNT_W'(w_count);
            r_filled_here  <= FILL_W'(w_run_used);
            r_filled_total <= w_total_sat;
            r_end_of_row   <= w_end_row;
            r_end_of_map   <= w_end_map;
        end
    end

    assign i_pix.ready        = w_in_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.fill_value   = r_fill_value;
    assign o_res.repeat_count = r_repeat_count;
    assign o_res.filled_here  = r_filled_here;
    assign o_res.filled_total = r_filled_total;
    assign o_res.end_of_row   = r_end_of_row;
    assign o_res.end_of_map   = r_end_of_map;

    `DHF_ASSERT_NOW(a_map_ends_row, i_clk, i_rst_n, o_res.valid && o_res.end_of_map,
        o_res.end_of_row, "end of map without end of row")
    `DHF_ASSERT_NOW(a_count_matches_filled, i_clk, i_rst_n, o_res.valid,
        o_res.repeat_count[FILL_W-1:0] == (o_res.filled_here + FILL_W'(1)),
        "repeat count disagrees with filled count")
    `DHF_ASSERT_NOW(a_run_after_lead, i_clk, i_rst_n, r_inside_run,
        r_past_lead && (r_run_len != '0), "run open before leading markers ended")
    `DHF_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, w_take && w_emit && w_end_map,
        (r_row == '0) && (r_total == '0) && (r_col == '0), "frame state not cleared")

endmodule
`default_nettype wire

// ===== verif/disparity_hole_fill_row_unit_tb.sv =====
// self-checking testbench of the disparity hole fill row unit with random stalls on both channels
`timescale 1ns / 1ps
module disparity_hole_fill_row_unit_tb;
    import dhf_pkg::*;

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int ITEMS      = 1550;
    localparam int CYCLE_CAP  = 500000;

    typedef struct {
        logic signed [PIX_W-1:0] fill_value;
        logic [CNT_W-1:0]        repeat_count;
        logic [FILL_W-1:0]       filled_here;
        logic [TOT_W-1:0]        filled_total;
        logic                    end_of_row;
        logic                    end_of_map;
    } t_fill_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    dhf_pix_if pix_if ();
    dhf_res_if res_if ();

    disparity_hole_fill_row_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // geometry as the block should currently see it
    logic [CFG_W-1:0]  geo_width = ROW_WIDTH_RST;
    logic [CFG_W-1:0]  geo_rows  = ROW_COUNT_RST;
    logic [SKIP_W-1:0] geo_skip  = SKIP_RST;

    // fill state of the predictor
    int col_idx     = 0;
    int row_idx     = 0;
    bit past_lead   = 1'b0;
    bit in_run      = 1'b0;
    int run_len     = 0;
    int frame_total = 0;

    t_fill_result         fill_exp[$];
    t_fill_result         want;
    logic [PIX_W-1:0]     pix_pend[$];
    int                   items_queued = 0;
    int                   items_taken  = 0;
    int                   errors       = 0;
    int                   cycle_count  = 0;

    bit pix_fire  = 1'b0;
    bit res_fire  = 1'b0;
    int tx_wait   = 0;
    bit tx_steady = 1'b0;
    int rx_wait   = 0;
    int rx_gap    = 0;
    bit rx_steady = 1'b0;
    int hold_left = 0;
    int next_hold = 200;
    bit run_open  = 1'b0;

    function int clamp_dim(logic [CFG_W-1:0] v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function void predict_fill(logic [PIX_W-1:0] px);
        int           w;
        int           h;
        int           cnt;
        int           tot;
        bit           marker;
        bit           neg;
        bit           row_end;
        bit           map_end;
        t_fill_result r;
        w       = clamp_dim(geo_width, MAX_W);
        h       = clamp_dim(geo_rows, MAX_H);
        marker  = (px == INVALID_CODE);
        neg     = px[PIX_W-1];
        row_end = (col_idx + 1 >= w);
        map_end = row_end && (row_idx + 1 >= h);
        cnt     = 1;
        if (in_run) begin
            // a run swallows negatives until a valid pixel or the row end
            if (neg && !row_end) begin
                run_len++;
                col_idx++;
                return;
            end
            cnt     = run_len + 1;
            in_run  = 1'b0;
            run_len = 0;
        end else if (col_idx < geo_skip) begin
            // skipped column, passed as is
        end else if (!past_lead) begin
            if (!marker) past_lead = 1'b1;
        end else if (marker && !row_end) begin
            in_run  = 1'b1;
            run_len = 1;
            col_idx++;
            return;
        end
        tot = frame_total + cnt - 1;
        if (tot > int'(TOTAL_MAX)) tot = int'(TOTAL_MAX);
        frame_total    = tot;
        r.fill_value   = px;
        r.repeat_count = CNT_W'(cnt);
        r.filled_here  = FILL_W'(cnt - 1);
        r.filled_total = TOT_W'(tot);
        r.end_of_row   = row_end;
        r.end_of_map   = map_end;
        fill_exp.push_back(r);
        if (row_end) begin
            col_idx   = 0;
            past_lead = 1'b0;
            in_run    = 1'b0;
            run_len   = 0;
            if (map_end) begin
                row_idx     = 0;
                frame_total = 0;
            end else begin
                row_idx++;
            end
        end else begin
            col_idx++;
        end
    endfunction

    function void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            errors++;
            $display("%0t ns %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
        end
    endfunction

    // tidy pixels keep runs going with negatives so that fills get long
    function logic [PIX_W-1:0] pick_pixel(bit tidy);
        logic [PIX_W-1:0] px;
        int               sel;
        sel = $urandom_range(0, 15);
        if (!tidy && sel < 6) begin
            px = PIX_W'($urandom);
        end else if (tidy && run_open && sel < 11) begin
            px = $urandom_range(0, 1) ? INVALID_CODE : {1'b1, 15'($urandom)};
        end else if (sel < 4) begin
            px = INVALID_CODE;
        end else if (sel == 4) begin
            px = {1'b1, 15'($urandom)};
        end else if (sel == 5) begin
            case ($urandom_range(0, 5))
                0: px = 16'h7FFF;
                1: px = 16'h8000;
                2: px = 16'h0000;
                3: px = 16'hFFFF;
                4: px = 16'hFFEF;
                default: px = 16'hFFF1;
            endcase
        end else begin
            px = {1'b0, 15'($urandom)};
        end
        run_open = (px == INVALID_CODE) || (run_open && px[PIX_W-1]);
        return px;
    endfunction

    task push_pixel(logic [PIX_W-1:0] px);
        pix_pend.push_back(px);
        items_queued++;
    endtask

    task program_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROW_WIDTH: geo_width = val;
            CFG_ROW_COUNT: geo_rows  = val;
            CFG_SKIP_COLS: geo_skip  = val[SKIP_W-1:0];
            default: ;
        endcase
    endtask

    task program_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [CFG_W-1:0] s);
        program_reg(CFG_ROW_WIDTH, w);
        program_reg(CFG_ROW_COUNT, h);
        program_reg(CFG_SKIP_COLS, s);
    endtask

    // wait until every item is taken and every result is back, then a tail
    task settle(int tail);
        while (items_taken != items_queued || fill_exp.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_CAP) begin
            $display("%0t ns timeout", $time);
            $display("disparity_hole_fill_row_unit test failed");
            $finish;
        end
    end

    // sender: offers queued pixels at falling edges with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (pix_if.valid && !pix_fire) begin
                // item still waiting for ready
            end else if (tx_wait != 0) begin
                tx_wait      <= tx_wait - 1;
                pix_if.valid <= 1'b0;
            end else if (pix_pend.size() != 0) begin
                pix_if.valid     <= 1'b1;
                pix_if.disparity <= pix_pend.pop_front();
                if ($urandom_range(0, 49) == 0) tx_steady <= !tx_steady;
                tx_wait <= tx_steady ? 0 : $urandom_range(0, 13);
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // receiver: random stall after each item, plus long hold-offs
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_fire) begin
                if ($urandom_range(0, 49) == 0) rx_steady <= !rx_steady;
                rx_gap = rx_steady ? 0 : $urandom_range(0, 13);
                rx_wait      <= rx_gap;
                res_if.ready <= (rx_gap == 0) && (hold_left == 0);
            end else if (rx_wait != 0) begin
                rx_wait      <= rx_wait - 1;
                res_if.ready <= (rx_wait == 1) && (hold_left == 0);
            end else begin
                res_if.ready <= (hold_left == 0);
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (items_taken >= next_hold) begin
            hold_left <= 150 + $urandom_range(0, 100);
            next_hold <= next_hold + 600;
        end
    end

    // monitor: checks results, then predicts from the pixel taken this edge
    always @(posedge i_clk) begin
        pix_fire <= i_rst_n && pix_if.valid && pix_if.ready;
        res_fire <= i_rst_n && res_if.valid && res_if.ready;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (fill_exp.size() == 0) begin
                    errors++;
                    $display("%0t ns unexpected result: expected none, %s %0d count %0d",
                             $time, "actual value", res_if.fill_value,
                             res_if.repeat_count);
                end else begin
                    want = fill_exp.pop_front();
                    check_field("fill_value", want.fill_value, res_if.fill_value);
                    check_field("repeat_count", want.repeat_count, res_if.repeat_count);
                    check_field("filled_here", want.filled_here, res_if.filled_here);
                    check_field("filled_total", want.filled_total, res_if.filled_total);
                    check_field("end_of_row", want.end_of_row, res_if.end_of_row);
                    check_field("end_of_map", want.end_of_map, res_if.end_of_map);
                end
            end
            if (pix_if.valid && pix_if.ready) begin
                predict_fill(pix_if.disparity);
                items_taken <= items_taken + 1;
            end
        end
    end

    initial begin
        int               phase_no;
        int               n;
        int               sel;
        bit               tidy;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] s;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_ROW_WIDTH;
        i_cfg_data       = '0;
        pix_if.valid     = 1'b0;
        pix_if.disparity = '0;
        res_if.ready     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: leading marker, valid pixel, then a run left open
        push_pixel(INVALID_CODE);
        push_pixel(16'h7FFF);
        push_pixel(INVALID_CODE);
        push_pixel(16'h8000);
        push_pixel(16'hFFFF);
        settle(3);

        // narrower row while the run is open: next pixel ends the row
        program_geometry(11'd6, 11'd2, 11'd1);
        push_pixel(16'h0000);
        // skip column, leading marker, run that hits the row end on a negative
        push_pixel(INVALID_CODE);
        push_pixel(INVALID_CODE);
        push_pixel(16'h0010);
        push_pixel(INVALID_CODE);
        push_pixel(INVALID_CODE);
        push_pixel(16'h8001);
        settle(3);

        // run closed by the row end, then a marker on the last column
        program_geometry(11'd3, 11'd1, 11'd0);
        push_pixel(16'h0005);
        push_pixel(INVALID_CODE);
        push_pixel(INVALID_CODE);
        push_pixel(16'h0001);
        push_pixel(16'h0002);
        push_pixel(INVALID_CODE);
        settle(3);

        // zero sizes act as one, skip at its top
        program_geometry(11'd0, 11'd0, 11'd1023);
        push_pixel(INVALID_CODE);
        push_pixel(16'h7FFF);
        settle(3);

        // skip wider than the row
        program_geometry(11'd4, 11'd1, 11'd7);
        repeat (4) push_pixel(INVALID_CODE);
        settle(3);

        phase_no = 0;
        while (items_queued < ITEMS) begin
            n    = $urandom_range(40, 120);
            tidy = ($urandom_range(0, 4) != 0);
            if (phase_no == 0) begin
                w = 11'd2047;
                h = 11'd2047;
                s = CFG_W'($urandom_range(0, 3));
                n = 40;
            end else if (phase_no == 1) begin
                w = 11'd1024;
                h = 11'd1024;
                s = 11'd0;
                n = 40;
            end else begin
                sel = $urandom_range(0, 19);
                if (sel == 0) w = 11'd0;
                else if (sel == 1) w = 11'd1;
                else if (sel == 2) w = 11'd2;
                else w = CFG_W'($urandom_range(2, 12));
                sel = $urandom_range(0, 19);
                if (sel == 0) h = 11'd0;
                else if (sel == 1) h = 11'd2047;
                else h = CFG_W'($urandom_range(1, 4));
                sel = $urandom_range(0, 9);
                if (sel < 6) s = 11'd0;
                else if (sel < 8) s = CFG_W'($urandom_range(1, (w == 0) ? 1 : w));
                else if (sel == 8) s = CFG_W'($urandom_range(0, 1023));
                else s = 11'd1023;
            end
            program_geometry(w, h, s);
            repeat (n) push_pixel(pick_pixel(tidy));
            settle(3);
            phase_no++;
        end

        settle(10);
        if (fill_exp.size() != 0) begin
            errors++;
            $display("%0t ns %0d expected results never arrived", $time, fill_exp.size());
        end
        if (errors == 0) begin
            $display("disparity_hole_fill_row_unit test passed");
        end else begin
            $display("disparity_hole_fill_row_unit test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/dhf_pkg.sv
sv/dhf_pix_if.sv
sv/dhf_res_if.sv
sv/disparity_hole_fill_row_unit.sv
verif/disparity_hole_fill_row_unit_tb.sv
